>>> hw/rtl/csem_pkg.sv
// Shared types, codes and defaults for the counting semaphore table.
`default_nettype none

package csem_pkg;

    // Default sizes
    localparam int SEM_SLOTS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 16;

    // Field widths
    localparam int ID_W     = 16;
    localparam int COUNT_W  = 16;
    localparam int PID_W    = 8;
    localparam int USERS_W  = 8;
    localparam int STATUS_W = 3;
    localparam int ACTION_W = 2;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 32;

    // Operation codes
    typedef enum logic [1:0] {
        OP_OPEN  = 2'd0,
        OP_WAIT  = 2'd1,
        OP_POST  = 2'd2,
        OP_CLOSE = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_UNKNOWN = 3'd1,
        ST_FULL    = 3'd2,
        ST_QFULL   = 3'd3,
        ST_WAITERS = 3'd4
    } status_t;

    // Result action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE  = 2'd0,
        ACT_BLOCK = 2'd1,
        ACT_WAKE  = 2'd2
    } action_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic encode;
        logic commit;
    } csem_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_busy;
        logic out_valid;
    } csem_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/csem_ctrl.sv
// Sequencer for the semaphore table: capture, slot select, fetch, commit.
`default_nettype none

module csem_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire csem_pkg::csem_sts_t sts,
    output csem_pkg::csem_cmd_t     cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ENC,
        S_RD,
        S_EXEC
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    // Command decode
    always_comb
    begin
        cmd.capture = ready_reg && s_tvalid;
        cmd.encode  = (state_reg == S_ENC);
        cmd.commit  = (state_reg == S_EXEC) && !sts.out_busy;
    end

    assign s_tready = ready_reg;

    // State and registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid && ready_reg)
                    begin
                        state_reg <= S_ENC;
                        ready_reg <= 1'b0;
                    end
                end
                S_ENC:
                begin
                    state_reg <= S_RD;
                end
                S_RD:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (!sts.out_busy)
                    begin
                        state_reg <= S_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Ready is only offered while idle
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg == (state_reg == S_IDLE))
        else $error("ready out of step with idle state");

    // A result is never committed over an unread one
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(sts.out_valid && sts.out_busy))
        else $error("commit while output register busy");

    // A captured request goes to slot selection next
    a_capture_enc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == S_ENC))
        else $error("capture not followed by slot select");

    // At most one command per cycle
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("overlapping commands");

endmodule

`default_nettype wire

>>> hw/rtl/csem_dp.sv
// Datapath: id match, entry and wait-queue memories, operation logic, output register.
`default_nettype none

module csem_dp #(
    parameter int SEM_SLOTS   = csem_pkg::SEM_SLOTS_DEF,
    parameter int QUEUE_DEPTH = csem_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire csem_pkg::csem_cmd_t        cmd,
    output csem_pkg::csem_sts_t             sts,
    input  wire logic [csem_pkg::IN_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [csem_pkg::OUT_W-1:0]      m_tdata
);

    localparam int SLOT_W   = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;
    localparam int QP_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QL_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int QS_W     = QL_W + 1;
    localparam int WQ_DEPTH = SEM_SLOTS * (2 ** QP_W);
    localparam int WQ_W     = SLOT_W + QP_W;

    localparam logic [QL_W-1:0] QD_LEN = QL_W'(QUEUE_DEPTH);
    localparam logic [QS_W-1:0] QD_SUM = QS_W'(QUEUE_DEPTH);

    // Slot table: id and valid in flops for the parallel match
    logic [SEM_SLOTS-1:0]         entry_valid_reg;
    logic [csem_pkg::ID_W-1:0]    entry_id_reg [SEM_SLOTS];

    // Per-slot memories
    logic [csem_pkg::COUNT_W-1:0] count_mem [SEM_SLOTS];
    logic [csem_pkg::USERS_W-1:0] users_mem [SEM_SLOTS];
    logic [QP_W-1:0]              head_mem  [SEM_SLOTS];
    logic [QL_W-1:0]              len_mem   [SEM_SLOTS];
    logic [csem_pkg::PID_W-1:0]   waiter_mem [WQ_DEPTH];

    // Captured request
    csem_pkg::op_t                op_reg;
    logic [csem_pkg::COUNT_W-1:0] init_reg;
    logic [csem_pkg::PID_W-1:0]   pid_reg;
    logic [SEM_SLOTS-1:0]         hit_vec_reg;
    logic [SEM_SLOTS-1:0]         free_vec_reg;
    logic [SEM_SLOTS-1:0]         hit_vec_c;

    // Id of the captured request, kept for the create write
    logic [csem_pkg::ID_W-1:0]    s_tdata_id_hold;

    // Slot selection
    logic [SLOT_W-1:0] hit_idx_c;
    logic [SLOT_W-1:0] free_idx_c;
    logic              hit_any_c;
    logic              free_any_c;
    logic [SLOT_W-1:0] slot_c;
    logic [SLOT_W-1:0] slot_reg;
    logic              found_reg;
    logic              create_reg;

    // Read data
    logic [csem_pkg::COUNT_W-1:0] count_rd_reg;
    logic [csem_pkg::USERS_W-1:0] users_rd_reg;
    logic [QP_W-1:0]              head_rd_reg;
    logic [QL_W-1:0]              len_rd_reg;
    logic [csem_pkg::PID_W-1:0]   pid_rd_reg;

    // Effective entry and queue position
    logic [csem_pkg::COUNT_W-1:0] count_c;
    logic [csem_pkg::USERS_W-1:0] users_c;
    logic [QP_W-1:0]              head_c;
    logic [QL_W-1:0]              len_c;
    logic [QS_W-1:0]              tail_sum_c;
    logic [QS_W-1:0]              head_inc_c;
    logic [QP_W-1:0]              tail_c;
    logic [QP_W-1:0]              head_wrap_c;
    logic [QP_W-1:0]              qpos_c;

    // Operation results
    csem_pkg::status_t            status_c;
    csem_pkg::action_t            action_c;
    logic [csem_pkg::PID_W-1:0]   wake_c;
    logic [csem_pkg::COUNT_W-1:0] cnt_c;
    logic [csem_pkg::COUNT_W-1:0] count_nx;
    logic [csem_pkg::USERS_W-1:0] users_nx;
    logic [QP_W-1:0]              head_nx;
    logic [QL_W-1:0]              len_nx;
    logic                         enq_c;
    logic                         clear_c;

    // Output register
    logic                         m_tvalid_reg;
    logic [csem_pkg::OUT_W-1:0]   m_tdata_reg;

    // Parallel id compare against valid entries
    always_comb
    begin
        for (int i = 0; i < SEM_SLOTS; i++)
        begin
            hit_vec_c[i] = entry_valid_reg[i] && (entry_id_reg[i] == s_tdata[17:2]);
        end
    end

    // Request capture with match vectors
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= csem_pkg::op_t'(s_tdata[1:0]);
            init_reg     <= s_tdata[33:18];
            pid_reg      <= s_tdata[41:34];
            hit_vec_reg  <= hit_vec_c;
            free_vec_reg <= ~entry_valid_reg;
        end
    end

    // Lowest matching slot and lowest free slot
    always_comb
    begin
        hit_idx_c  = '0;
        free_idx_c = '0;
        hit_any_c  = 1'b0;
        free_any_c = 1'b0;
        for (int i = SEM_SLOTS - 1; i >= 0; i--)
        begin
            if (hit_vec_reg[i])
            begin
                hit_idx_c = SLOT_W'(i);
                hit_any_c = 1'b1;
            end
            if (free_vec_reg[i])
            begin
                free_idx_c = SLOT_W'(i);
                free_any_c = 1'b1;
            end
        end
        slot_c = hit_any_c ? hit_idx_c : free_idx_c;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.encode)
        begin
            slot_reg   <= slot_c;
            found_reg  <= hit_any_c;
            create_reg <= (op_reg == csem_pkg::OP_OPEN) && !hit_any_c && free_any_c;
        end
    end

    // Entry read, registered
    always_ff @(posedge clk)
    begin
        count_rd_reg <= count_mem[slot_c];
        users_rd_reg <= users_mem[slot_c];
        head_rd_reg  <= head_mem[slot_c];
        len_rd_reg   <= len_mem[slot_c];
    end

    // A newly opened entry starts from init with an empty queue
    always_comb
    begin
        count_c = create_reg ? init_reg : count_rd_reg;
        users_c = create_reg ? '0 : users_rd_reg;
        head_c  = create_reg ? '0 : head_rd_reg;
        len_c   = create_reg ? '0 : len_rd_reg;
    end

    // Queue positions: tail for enqueue, head for dequeue, both wrapping
    always_comb
    begin
        tail_sum_c  = QS_W'(head_c) + {1'b0, len_c};
        tail_c      = (tail_sum_c >= QD_SUM) ? QP_W'(tail_sum_c - QD_SUM)
                                             : QP_W'(tail_sum_c);
        head_inc_c  = QS_W'(head_c) + QS_W'(1);
        head_wrap_c = (head_inc_c == QD_SUM) ? '0 : QP_W'(head_inc_c);
        qpos_c      = (op_reg == csem_pkg::OP_WAIT) ? tail_c : head_c;
    end

    // Waiter read at the queue position (the head, or the tail for a wait), registered
    always_ff @(posedge clk)
    begin
        pid_rd_reg <= waiter_mem[{slot_reg, qpos_c}];
    end

    // Operation logic
    always_comb
    begin
        status_c = csem_pkg::ST_OK;
        action_c = csem_pkg::ACT_NONE;
        wake_c   = '0;
        cnt_c    = '0;
        count_nx = count_c;
        users_nx = users_c;
        head_nx  = head_c;
        len_nx   = len_c;
        enq_c    = 1'b0;
        clear_c  = 1'b0;
        priority if (op_reg == csem_pkg::OP_OPEN)
        begin
            if (!found_reg && !create_reg)
            begin
                status_c = csem_pkg::ST_FULL;
            end
            else
            begin
                if (users_c != '1)
                begin
                    users_nx = users_c + 1'b1;
                end
                cnt_c = count_c;
            end
        end
        else if (!found_reg)
        begin
            status_c = csem_pkg::ST_UNKNOWN;
        end
        else
        begin
            unique case (op_reg)
                csem_pkg::OP_WAIT:
                begin
                    if (count_c != '0)
                    begin
                        count_nx = count_c - 1'b1;
                    end
                    else if (len_c == QD_LEN)
                    begin
                        status_c = csem_pkg::ST_QFULL;
                    end
                    else
                    begin
                        enq_c    = 1'b1;
                        len_nx   = len_c + 1'b1;
                        action_c = csem_pkg::ACT_BLOCK;
                    end
                    cnt_c = count_nx;
                end
                csem_pkg::OP_POST:
                begin
                    if (len_c != '0)
                    begin
                        wake_c   = pid_rd_reg;
                        head_nx  = head_wrap_c;
                        len_nx   = len_c - 1'b1;
                        action_c = csem_pkg::ACT_WAKE;
                    end
                    else if (count_c != '1)
                    begin
                        count_nx = count_c + 1'b1;
                    end
                    cnt_c = count_nx;
                end
                csem_pkg::OP_CLOSE:
                begin
                    users_nx = (users_c != '0) ? users_c - 1'b1 : '0;
                    cnt_c    = count_c;
                    if (users_nx == '0)
                    begin
                        if (len_c != '0)
                        begin
                            status_c = csem_pkg::ST_WAITERS;
                        end
                        else
                        begin
                            clear_c = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Memory write-back
    always_ff @(posedge clk)
    begin
        if (cmd.commit && (found_reg || create_reg))
        begin
            count_mem[slot_reg] <= count_nx;
            users_mem[slot_reg] <= users_nx;
            head_mem[slot_reg]  <= head_nx;
            len_mem[slot_reg]   <= len_nx;
        end
        if (cmd.commit && enq_c)
        begin
            waiter_mem[{slot_reg, qpos_c}] <= pid_reg;
        end
        if (cmd.commit && create_reg)
        begin
            entry_id_reg[slot_reg] <= s_tdata_id_hold;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            s_tdata_id_hold <= s_tdata[17:2];
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (create_reg)
            begin
                entry_valid_reg[slot_reg] <= 1'b1;
            end
            else if (clear_c)
            begin
                entry_valid_reg[slot_reg] <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            m_tdata_reg <= {3'b000, cnt_c, wake_c, action_c, status_c};
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;
    assign sts.out_busy  = m_tvalid_reg && !m_tready;
    assign sts.out_valid = m_tvalid_reg;

    // A created entry always lands in a free slot
    a_create_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && create_reg |-> !entry_valid_reg[slot_reg])
        else $error("create into an occupied slot");

    // A commit always leaves a result waiting
    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_tvalid_reg)
        else $error("commit did not load output register");

    // An id never matches two slots
    a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.encode |-> $onehot0(hit_vec_reg))
        else $error("id present in more than one slot");

endmodule

`default_nettype wire

>>> hw/rtl/counting_semaphore_table.sv
// Top level of the counting semaphore table: controller plus datapath.
//
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tdata: opcode, sem_id, init_value, caller_pid
// m_*      out  m_tvalid/m_tready  m_tdata: status, action, wake_pid, count_after
//
// The id match runs in the accepting cycle; after acceptance come slot select with
// entry memory read, wait-queue memory read, then commit, which loads the result.
// The wait-queue read depends on the entry read, which sets the length.
// One request is in flight at a time; a new one is accepted once the previous
// result sits in the output register, while that result waits for m_tready.
// Commit stalls while an unread result blocks the register.
// Reset clears the valid bits and handshake state; no clearing pass is needed.
`default_nettype none

module counting_semaphore_table #(
    parameter int SEM_SLOTS   = csem_pkg::SEM_SLOTS_DEF,
    parameter int QUEUE_DEPTH = csem_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // [1:0] opcode, [17:2] sem_id, [33:18] init_value, [41:34] caller_pid
    input  wire logic [csem_pkg::IN_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // [2:0] status, [4:3] action, [12:5] wake_pid, [28:13] count_after
    output logic [csem_pkg::OUT_W-1:0]      m_tdata
);

    csem_pkg::csem_cmd_t cmd;
    csem_pkg::csem_sts_t sts;

    csem_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    csem_dp #(
        .SEM_SLOTS   (SEM_SLOTS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

>>> tb/counting_semaphore_table_checker.sv
// Checker for the counting semaphore table: models the table and scores every result.
`timescale 1ns / 1ps

module counting_semaphore_table_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    // [1:0] opcode, [17:2] sem_id, [33:18] init_value, [41:34] caller_pid
    input  logic [csem_pkg::IN_W-1:0]    s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    // [2:0] status, [4:3] action, [12:5] wake_pid, [28:13] count_after
    input  logic [csem_pkg::OUT_W-1:0]   m_tdata,
    output int                           errors,
    output int                           pending,
    output int                           checked,
    output logic [4:0]                   status_seen,
    output logic [2:0]                   action_seen
);

    localparam int SLOTS = csem_pkg::SEM_SLOTS_DEF;
    localparam int DEPTH = csem_pkg::QUEUE_DEPTH_DEF;

    typedef struct packed {
        csem_pkg::status_t                 status;
        csem_pkg::action_t                 action;
        logic [csem_pkg::PID_W-1:0]        wake_pid;
        logic [csem_pkg::COUNT_W-1:0]      count;
    } sem_result_t;

    // Shadow copy of the semaphore table
    logic                              sem_live   [SLOTS];
    logic [csem_pkg::ID_W-1:0]         sem_key    [SLOTS];
    logic [csem_pkg::COUNT_W-1:0]      shadow_cnt [SLOTS];
    logic [csem_pkg::USERS_W-1:0]      sem_users  [SLOTS];
    logic [csem_pkg::PID_W-1:0]        waiter_q   [SLOTS][DEPTH];
    int                                q_head     [SLOTS];
    int                                q_len      [SLOTS];

    sem_result_t         expected_results[$];
    int                  err_total;
    int                  result_total;
    logic [4:0]          status_mask;
    logic [2:0]          action_mask;

    // Apply one request to the shadow table and return the result it must produce
    function automatic sem_result_t apply_request(csem_pkg::op_t op,
                                                  logic [csem_pkg::ID_W-1:0] id,
                                                  logic [csem_pkg::COUNT_W-1:0] init,
                                                  logic [csem_pkg::PID_W-1:0] pid);
        sem_result_t r;
        int          slot;
        int          pos;
        r.status   = csem_pkg::ST_OK;
        r.action   = csem_pkg::ACT_NONE;
        r.wake_pid = '0;
        r.count    = '0;
        slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--)
            if (sem_live[i] && sem_key[i] == id)
                slot = i;

        if (op == csem_pkg::OP_OPEN)
        begin
            // new id takes the lowest free slot
            if (slot < 0)
            begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!sem_live[i])
                        slot = i;
                if (slot >= 0)
                begin
                    sem_live[slot]   = 1'b1;
                    sem_key[slot]    = id;
                    shadow_cnt[slot] = init;
                    sem_users[slot]  = '0;
                    q_head[slot]     = 0;
                    q_len[slot]      = 0;
                end
            end
            if (slot < 0)
                r.status = csem_pkg::ST_FULL;
            else
            begin
                if (sem_users[slot] != '1)
                    sem_users[slot]++;
                r.count = shadow_cnt[slot];
            end
        end
        else if (slot < 0)
            r.status = csem_pkg::ST_UNKNOWN;
        else if (op == csem_pkg::OP_WAIT)
        begin
            if (shadow_cnt[slot] != '0)
                shadow_cnt[slot]--;
            else if (q_len[slot] >= DEPTH)
                r.status = csem_pkg::ST_QFULL;
            else
            begin
                pos = (q_head[slot] + q_len[slot]) % DEPTH;
                waiter_q[slot][pos] = pid;
                q_len[slot]++;
                r.action = csem_pkg::ACT_BLOCK;
            end
            r.count = shadow_cnt[slot];
        end
        else if (op == csem_pkg::OP_POST)
        begin
            // a waiter gets the unit directly; otherwise count up, saturating
            if (q_len[slot] > 0)
            begin
                r.wake_pid   = waiter_q[slot][q_head[slot]];
                q_head[slot] = (q_head[slot] + 1) % DEPTH;
                q_len[slot]--;
                r.action     = csem_pkg::ACT_WAKE;
            end
            else if (shadow_cnt[slot] != '1)
                shadow_cnt[slot]++;
            r.count = shadow_cnt[slot];
        end
        else
        begin
            if (sem_users[slot] != '0)
                sem_users[slot]--;
            r.count = shadow_cnt[slot];
            if (sem_users[slot] == '0)
            begin
                if (q_len[slot] > 0)
                    r.status = csem_pkg::ST_WAITERS;
                else
                    sem_live[slot] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch on result %0d: expected %0d, actual %0d",
                     $time, name, result_total, want, got);
            err_total++;
        end
    endfunction

    // Track accepted requests and score returned results
    always @(posedge clk or negedge rst_n)
    begin
        sem_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                sem_live[i] = 1'b0;
                q_head[i]   = 0;
                q_len[i]    = 0;
            end
            expected_results.delete();
            err_total    = 0;
            result_total = 0;
            status_mask  = '0;
            action_mask  = '0;
            errors       <= 0;
            pending      <= 0;
            checked      <= 0;
            status_seen  <= '0;
            action_seen  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_request(csem_pkg::op_t'(s_tdata[1:0]),
                                                         s_tdata[17:2], s_tdata[33:18],
                                                         s_tdata[41:34]));

            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t ns: result with no request outstanding, expected none, actual %h",
                             $time, m_tdata);
                    err_total++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, m_tdata[2:0]);
                    check_field("action", want.action, m_tdata[4:3]);
                    check_field("wake_pid", want.wake_pid, m_tdata[12:5]);
                    check_field("count_after", want.count, m_tdata[28:13]);
                end
                if (m_tdata[2:0] <= csem_pkg::ST_WAITERS)
                    status_mask[m_tdata[2:0]] = 1'b1;
                if (m_tdata[4:3] <= csem_pkg::ACT_WAKE)
                    action_mask[m_tdata[4:3]] = 1'b1;
                result_total++;
            end

            errors      <= err_total;
            pending     <= expected_results.size();
            checked     <= result_total;
            status_seen <= status_mask;
            action_seen <= action_mask;
        end
    end

endmodule

>>> tb/counting_semaphore_table_tb.sv
// Testbench top for the counting semaphore table: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module counting_semaphore_table_tb;

    typedef logic [csem_pkg::ID_W-1:0]    id_t;
    typedef logic [csem_pkg::COUNT_W-1:0] cnt_t;
    typedef logic [csem_pkg::PID_W-1:0]   pid_t;

    localparam int          TOTAL_ITEMS  = 700;
    localparam int          IDLE_LIMIT   = 4000;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          POOL_SIZE    = 8;
    localparam int          FILL_COUNT   = csem_pkg::SEM_SLOTS_DEF + 2;
    localparam int          QDEPTH       = csem_pkg::QUEUE_DEPTH_DEF;
    localparam logic [15:0] SAT_ID       = 16'hA5A5;

    logic                           clk;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    // [1:0] opcode, [17:2] sem_id, [33:18] init_value, [41:34] caller_pid
    logic [csem_pkg::IN_W-1:0]      s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    // [2:0] status, [4:3] action, [12:5] wake_pid, [28:13] count_after
    logic [csem_pkg::OUT_W-1:0]     m_tdata;

    int                 errors;
    int                 pending;
    int                 checked;
    logic [4:0]         status_seen;
    logic [2:0]         action_seen;

    int                 sent_count = 0;
    int                 burst_left = 0;
    int                 idle_cycles = 0;
    int                 rx_mode = 0;
    int                 rx_left = 0;
    int                 rx_stall = 0;

    counting_semaphore_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    counting_semaphore_table_checker sem_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .pending     (pending),
        .checked     (checked),
        .status_seen (status_seen),
        .action_seen (action_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Send one request; the sender runs in bursts with random gaps between them
    task automatic send_request(csem_pkg::op_t op, id_t id, cnt_t init, pid_t pid);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(csem_pkg::IN_W - 42){1'b0}}, pid, init, id, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
        sent_count++;
    endtask

    // Random pid and id helpers
    function automatic pid_t random_pid();
        return pid_t'($urandom_range(0, 255));
    endfunction

    function automatic id_t random_id();
        return id_t'($urandom_range(0, 65535));
    endfunction

    // Initial counts lean toward zero and toward the saturation point
    function automatic cnt_t random_init();
        int pick;
        pick = $urandom_range(0, 3);
        if (pick < 2)
            return cnt_t'($urandom_range(0, 3));
        else if (pick == 2)
            return cnt_t'($urandom_range(0, 65535));
        else
            return cnt_t'($urandom_range(65530, 65535));
    endfunction

    // Result side: ready pattern switches between randomly chosen modes
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(40, 160);
            end
            rx_left--;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 1) == 1);
                2:       m_tready <= (rx_left % 3 == 0);
                default:
                begin
                    // long stalls broken by single ready cycles
                    if (rx_stall > 0)
                    begin
                        rx_stall--;
                        m_tready <= 1'b0;
                    end
                    else
                    begin
                        rx_stall = $urandom_range(1, 12);
                        m_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
                         $time, IDLE_LIMIT, pending);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        id_t             id_pool [POOL_SIZE];
        id_t             fill_ids [FILL_COUNT];
        id_t             qid;
        csem_pkg::op_t   op;
        int              pick;
        int              n_ops;
        int              n_wait;
        int              w;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unknown id on an empty table
        send_request(csem_pkg::OP_WAIT,  16'h0000, 16'h0000, 8'h00);
        send_request(csem_pkg::OP_POST,  16'h0000, 16'hFFFF, 8'hFF);
        send_request(csem_pkg::OP_CLOSE, 16'h0000, 16'h0000, 8'h00);
        // Create with zero count, reopen keeps the count, two waiters queue up
        send_request(csem_pkg::OP_OPEN,  16'h0000, 16'h0000, 8'h00);
        send_request(csem_pkg::OP_OPEN,  16'h0000, 16'hFFFF, 8'hFF);
        send_request(csem_pkg::OP_WAIT,  16'h0000, 16'h0000, 8'hFF);
        send_request(csem_pkg::OP_WAIT,  16'h0000, 16'hFFFF, 8'h00);
        // Last user leaves while waiters remain
        send_request(csem_pkg::OP_CLOSE, 16'h0000, 16'h0000, 8'h00);
        send_request(csem_pkg::OP_CLOSE, 16'h0000, 16'h0000, 8'h00);
        // Posts wake in order, then bump the count
        send_request(csem_pkg::OP_POST,  16'h0000, 16'h0000, 8'h00);
        send_request(csem_pkg::OP_POST,  16'h0000, 16'h0000, 8'h00);
        send_request(csem_pkg::OP_POST,  16'h0000, 16'h0000, 8'h00);
        send_request(csem_pkg::OP_WAIT,  16'h0000, 16'h0000, 8'h5A);
        // Entry with no users and no waiters is freed
        send_request(csem_pkg::OP_CLOSE, 16'h0000, 16'h0000, 8'h00);
        send_request(csem_pkg::OP_POST,  16'h0000, 16'h0000, 8'h00);
        // Count saturation at the top id
        send_request(csem_pkg::OP_OPEN,  16'hFFFF, 16'hFFFF, 8'hFF);
        send_request(csem_pkg::OP_POST,  16'hFFFF, 16'h0000, 8'hFF);
        send_request(csem_pkg::OP_WAIT,  16'hFFFF, 16'h0000, 8'hFF);
        send_request(csem_pkg::OP_POST,  16'hFFFF, 16'h0000, 8'hFF);
        send_request(csem_pkg::OP_POST,  16'hFFFF, 16'h0000, 8'hFF);
        send_request(csem_pkg::OP_CLOSE, 16'hFFFF, 16'h0000, 8'hFF);

        // Users saturation: one close after 256 opens must not free the entry
        repeat (256)
            send_request(csem_pkg::OP_OPEN, SAT_ID, 16'd5, random_pid());
        send_request(csem_pkg::OP_CLOSE, SAT_ID, 16'd0, 8'h00);
        send_request(csem_pkg::OP_WAIT,  SAT_ID, 16'd0, 8'h33);

        // Random part
        foreach (id_pool[i])
            id_pool[i] = random_id();
        while (sent_count < TOTAL_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                // mixed operations on a small set of ids
                n_ops = $urandom_range(4, 12);
                repeat (n_ops)
                begin
                    w  = $urandom_range(0, 99);
                    op = (w < 25) ? csem_pkg::OP_OPEN :
                         (w < 55) ? csem_pkg::OP_WAIT :
                         (w < 85) ? csem_pkg::OP_POST : csem_pkg::OP_CLOSE;
                    send_request(op, id_pool[$urandom_range(0, POOL_SIZE - 1)], random_init(),
                                 random_pid());
                end
            end
            else if (pick < 68)
            begin
                // fill a wait queue near or past its depth, drain it, then a second shorter round
                qid = random_id();
                send_request(csem_pkg::OP_OPEN, qid, cnt_t'($urandom_range(0, 2)), random_pid());
                n_wait = $urandom_range(QDEPTH - 3, QDEPTH + 2);
                repeat (n_wait)
                    send_request(csem_pkg::OP_WAIT, qid, random_init(), random_pid());
                if ($urandom_range(0, 1) == 1)
                    send_request(csem_pkg::OP_CLOSE, qid, 16'd0, random_pid());
                repeat (n_wait + 2)
                    send_request(csem_pkg::OP_POST, qid, random_init(), random_pid());
                n_wait = $urandom_range(1, 8);
                repeat (n_wait)
                    send_request(csem_pkg::OP_WAIT, qid, random_init(), random_pid());
                repeat (n_wait + 1)
                    send_request(csem_pkg::OP_POST, qid, random_init(), random_pid());
                send_request(csem_pkg::OP_CLOSE, qid, 16'd0, random_pid());
            end
            else if (pick < 78)
            begin
                // open more ids than there are slots, then close them all
                foreach (fill_ids[i])
                begin
                    fill_ids[i] = random_id();
                    send_request(csem_pkg::OP_OPEN, fill_ids[i], random_init(), random_pid());
                end
                foreach (fill_ids[i])
                    send_request(csem_pkg::OP_CLOSE, fill_ids[i], random_init(), random_pid());
            end
            else
            begin
                // noise: any operation on any id
                n_ops = $urandom_range(2, 10);
                repeat (n_ops)
                    send_request(csem_pkg::op_t'($urandom_range(0, 3)), random_id(),
                                 cnt_t'($urandom_range(0, 65535)), random_pid());
            end
        end
        s_tvalid <= 1'b0;

        // Let the last result come back, then watch for strays
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests (directed, users saturation, random mix), checked %0d results",
                 sent_count, checked);
        $display("Status codes returned, one bit per code from ok up: %05b; actions: %03b",
                 status_seen, action_seen);
        if (errors == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/csem_pkg.sv
hw/rtl/csem_ctrl.sv
hw/rtl/csem_dp.sv
hw/rtl/counting_semaphore_table.sv
tb/counting_semaphore_table_checker.sv
tb/counting_semaphore_table_tb.sv
